/* design/fsd_pkg.sv */
package fsd_pkg;

	// Configuration port layout.
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

	localparam cfg_index_t REG_IMAGE_WIDTH  = 1'd0;
	localparam cfg_index_t REG_IMAGE_HEIGHT = 1'd1;

	// Register widths and reset values.
	localparam int WIDTH_REG_W  = 13;
	localparam int HEIGHT_REG_W = 16;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 13'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

endpackage

/* design/floyd_steinberg_dither.sv */
// Floyd-Steinberg halftoner for a raster stream of 8-bit grey pixels. Every pixel transfer
// on the input side yields exactly one result transfer carrying the black/white bit and
// end-of-row / end-of-frame marks derived from the image_width and image_height registers
// (a value of zero counts as one, a width above MAX_WIDTH counts as MAX_WIDTH). The block
// sustains one pixel per clock while the result side keeps taking results. A pixel
// transfer starts the line-buffer read and loads stage 1, and the single quantize stage
// that follows ends in the output register; that stage also closes the loop through the
// carry to the right-hand neighbour. The line buffer holds MAX_WIDTH entries of error
// owed to the next row; it is not cleared after reset, since the first row of every
// frame ignores it and each later row only reads columns written by the row above.
// Registers should only be written while the block is idle.
module floyd_steinberg_dither #(
	parameter int MAX_WIDTH     = 4096,
	parameter int FRACTION_BITS = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    cfg_wr_en,
	input  fsd_pkg::cfg_index_t     cfg_index,
	input  fsd_pkg::cfg_data_t      cfg_data,

	input  logic                    pixel_valid,
	output logic                    pixel_ready,
	input  logic [7:0]              grey_pixel,

	output logic                    result_valid,
	input  logic                    result_ready,
	output logic                    halftone_bit,
	output logic                    end_of_row,
	output logic                    end_of_frame
);

	import fsd_pkg::*;

	// Column address width, a width wide enough to hold MAX_WIDTH itself, and the error
	// word width: ten integer bits cover the grey range plus error headroom.
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = AW + 1;
	localparam int EB = FRACTION_BITS + 10;

	localparam logic signed [EB:0]   WHITE   = (EB+1)'(255 << FRACTION_BITS);
	localparam logic signed [EB-1:0] ERR_MAX = {1'b0, {(EB-1){1'b1}}};
	localparam logic signed [EB-1:0] ERR_MIN = {1'b1, {(EB-1){1'b0}}};

	// Saturate a sum that may have grown by one bit back to the error word width.
	function automatic logic signed [EB-1:0] sat_f(input logic signed [EB:0] v);
		logic signed [EB-1:0] r;
		if (v[EB] != v[EB-1]) begin
			r = v[EB] ? ERR_MIN : ERR_MAX;
		end else begin
			r = v[EB-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [EB:0] sext_f(input logic signed [EB-1:0] v);
		return $signed({v[EB-1], v});
	endfunction

	// ---------------------------------------------------------------------------------
	// Configuration registers.
	// ---------------------------------------------------------------------------------
	logic [WIDTH_REG_W-1:0]  image_width_q;
	logic [HEIGHT_REG_W-1:0] image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default:          ;
			endcase
		end
	end

	// Effective frame size after the zero and upper-limit rules.
	logic [CW-1:0]           width_eff;
	logic [HEIGHT_REG_W-1:0] height_eff;

	always_comb begin
		if (image_width_q == '0) begin
			width_eff = CW'(1);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			width_eff = CW'(MAX_WIDTH);
		end else begin
			width_eff = CW'(image_width_q);
		end
		height_eff = (image_height_q == '0) ? HEIGHT_REG_W'(1) : image_height_q;
	end

	// ---------------------------------------------------------------------------------
	// Handshake. Stage 1 holds one pixel together with its line-buffer word; it moves on
	// into the output register whenever that register is empty or being drained.
	// ---------------------------------------------------------------------------------
	logic valid_s1;
	logic out_valid_q;
	logic advance;
	logic pix_acc;

	assign advance     = valid_s1 && (!out_valid_q || result_ready);
	assign pixel_ready = !valid_s1 || advance;
	assign pix_acc     = pixel_valid && pixel_ready;

	// ---------------------------------------------------------------------------------
	// Position counters. They run on the input side so that the line-buffer read
	// address is known when the pixel transfer happens.
	// ---------------------------------------------------------------------------------
	logic [AW-1:0]           col_q;
	logic [HEIGHT_REG_W-1:0] row_q;
	logic                    last_col_c;
	logic                    last_row_c;

	assign last_col_c = (CW'(col_q) + CW'(1)) >= width_eff;
	assign last_row_c = ({1'b0, row_q} + 17'd1) >= {1'b0, height_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (last_col_c) begin
				col_q <= '0;
				row_q <= last_row_c ? '0 : row_q + HEIGHT_REG_W'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 1 pipeline registers.
	// ---------------------------------------------------------------------------------
	logic [7:0]    pixel_s1;
	logic [AW-1:0] col_s1;
	logic          row_nz_s1;
	logic          last_col_s1;
	logic          last_row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			pixel_s1    <= grey_pixel;
			col_s1      <= col_q;
			row_nz_s1   <= (row_q != '0);
			last_col_s1 <= last_col_c;
			last_row_s1 <= last_row_c;
		end
	end

	// ---------------------------------------------------------------------------------
	// Line buffer of error owed to the next row. A pixel at column c completes the entry
	// for column c-1; the last pixel of a row also completes its own column, and that
	// second write is held in a tail register and lands on the following edge, when the
	// first pixel of the next row never writes.
	// ---------------------------------------------------------------------------------
	logic signed [EB-1:0] line_mem [MAX_WIDTH];
	logic signed [EB-1:0] rdata_s1;

	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic signed [EB-1:0] wr_data;
	logic                 normal_we;
	logic signed [EB-1:0] normal_data;

	logic                 tail_valid_q;
	logic [AW-1:0]        tail_addr_q;
	logic signed [EB-1:0] tail_data_q;

	assign normal_we = advance && (col_s1 != '0);
	assign wr_en     = tail_valid_q || normal_we;
	assign wr_addr   = tail_valid_q ? tail_addr_q : col_s1 - AW'(1);
	assign wr_data   = tail_valid_q ? tail_data_q : normal_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[wr_addr] <= wr_data;
		end
		if (pix_acc) begin
			rdata_s1 <= line_mem[col_q];
		end
	end

	// Forwarding. The read returns the old word when a write to the same entry lands on
	// the same edge, and a tail write can also land while the reader waits in stage 1.
	// Such writes are caught here against the column that stage 1 holds after the edge.
	logic                 fwd_hit_s1;
	logic signed [EB-1:0] fwd_data_s1;
	logic [AW-1:0]        next_col_s1;

	assign next_col_s1 = pix_acc ? col_q : col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_s1 <= 1'b0;
		end else if (wr_en && (wr_addr == next_col_s1)) begin
			fwd_hit_s1 <= 1'b1;
		end else if (pix_acc) begin
			fwd_hit_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == next_col_s1)) begin
			fwd_data_s1 <= wr_data;
		end
	end

	// A tail write still pending in this cycle is the newest value of its entry.
	logic signed [EB-1:0] below_err;

	always_comb begin
		priority if (tail_valid_q && (tail_addr_q == col_s1)) begin
			below_err = tail_data_q;
		end else if (fwd_hit_s1) begin
			below_err = fwd_data_s1;
		end else begin
			below_err = rdata_s1;
		end
	end

	// ---------------------------------------------------------------------------------
	// Quantize and diffuse.
	// ---------------------------------------------------------------------------------
	logic signed [EB-1:0] right_carry_q;
	logic signed [EB-1:0] below_left_q;
	logic signed [EB-1:0] below_q;

	logic [EB-1:0]        pix_level;
	logic signed [EB:0]   sum_a;
	logic signed [EB:0]   sum_b;
	logic signed [EB-1:0] level_a;
	logic signed [EB-1:0] level;
	logic signed [EB:0]   twice_level;
	logic                 is_white;
	logic signed [EB:0]   err_wide;
	logic signed [EB-1:0] err;
	logic signed [EB+3:0] err_x;
	logic signed [EB+3:0] prod7;
	logic signed [EB+3:0] prod3;
	logic signed [EB+3:0] prod5;
	logic signed [EB-1:0] share7;
	logic signed [EB-1:0] share3;
	logic signed [EB-1:0] share5;
	logic signed [EB-1:0] share1;
	logic signed [EB-1:0] below_left_next;

	always_comb begin
		pix_level   = EB'(pixel_s1) << FRACTION_BITS;
		sum_a       = $signed({1'b0, pix_level}) + sext_f(right_carry_q);
		level_a     = sat_f(sum_a);
		sum_b       = sext_f(level_a) + (row_nz_s1 ? sext_f(below_err) : '0);
		level       = sat_f(sum_b);

		// White when the level reaches half scale.
		twice_level = $signed({level, 1'b0});
		is_white    = twice_level >= WHITE;
		err_wide    = is_white ? sext_f(level) - WHITE : sext_f(level);
		// The error always fits the word, whichever way the pixel went.
		err         = err_wide[EB-1:0];

		// Shares are floor(err * k / 16); dropping four bits of a two's complement
		// product rounds toward minus infinity.
		err_x  = $signed({{4{err[EB-1]}}, err});
		prod7  = (err_x <<< 3) - err_x;
		prod3  = (err_x <<< 1) + err_x;
		prod5  = (err_x <<< 2) + err_x;
		share7 = prod7[EB+3:4];
		share3 = prod3[EB+3:4];
		share5 = prod5[EB+3:4];
		share1 = err_x[EB+3:4];

		normal_data     = sat_f(sext_f(below_left_q) + sext_f(share3));
		below_left_next = sat_f(sext_f(below_q) + sext_f(share5));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_carry_q <= '0;
			below_left_q  <= '0;
			below_q       <= '0;
			tail_valid_q  <= 1'b0;
		end else begin
			tail_valid_q <= advance && last_col_s1;
			if (advance) begin
				if (last_col_s1) begin
					right_carry_q <= '0;
					below_left_q  <= '0;
					below_q       <= '0;
				end else begin
					right_carry_q <= share7;
					below_left_q  <= below_left_next;
					below_q       <= share1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tail_addr_q <= col_s1;
			tail_data_q <= below_left_next;
		end
	end

	// ---------------------------------------------------------------------------------
	// Output register. It decouples the result side so that a waiting result does not
	// stop the next pixel transfer.
	// ---------------------------------------------------------------------------------
	logic halftone_q;
	logic end_of_row_q;
	logic end_of_frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			halftone_q     <= is_white;
			end_of_row_q   <= last_col_s1;
			end_of_frame_q <= last_col_s1 && last_row_s1;
		end
	end

	assign result_valid = out_valid_q;
	assign halftone_bit = halftone_q;
	assign end_of_row   = end_of_row_q;
	assign end_of_frame = end_of_frame_q;

endmodule

/* dv/tb_floyd_steinberg_dither.sv */
// Self-checking bench for the Floyd-Steinberg halftoner.
//
// The bench keeps its own error-diffusion model of the block. Every pixel transfer that
// the block accepts is run through that model right away. The bit and the row and frame
// marks that the model predicts are queued in order. Each result transfer is compared
// with the oldest entry of the queue.
//
// Register writes happen only while the block is idle, which means no pixel is
// outstanding. Most of them fall on a frame boundary. A few fall on purpose in mid-frame
// and shrink the image or grow its height. In the first row they may also grow the width. Either way a
// row never reads a line-buffer column that the row above did not write.
module tb_floyd_steinberg_dither;
	import fsd_pkg::*;

	localparam int LINE_DEPTH     = 4096;
	localparam int FRAC           = 4;
	localparam int SHARE_SHIFT    = 4;	// shares are sixteenths of the error
	localparam int ERR_MAX        = 8191;	// 14-bit signed range
	localparam int ERR_MIN        = -8192;
	localparam int WHITE_LEVEL    = 255 << FRAC;
	localparam int IDLE_PERCENT   = 26;
	localparam int HOLD_CYCLES    = 60;
	localparam int SETTLE_CYCLES  = 6;	// idle margin after the last result has come back
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_TARGET  = 500;
	localparam int WIDE_PIXELS    = 300;

	typedef struct packed {
		logic halftone;
		logic row_end;
		logic frame_end;
	} halftone_result_t;

	// Pixel content styles for the random frames.
	typedef enum int {
		TEX_NOISE,
		TEX_FLAT,
		TEX_CHECKER,
		TEX_NEAR_MID
	} texture_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       cfg_wr_en = 1'b0;
	cfg_index_t cfg_index = REG_IMAGE_WIDTH;
	cfg_data_t  cfg_data = '0;

	logic       pixel_valid = 1'b0;
	logic       pixel_ready;
	logic [7:0] grey_pixel = 8'd0;

	logic result_valid;
	logic result_ready = 1'b0;
	logic halftone_bit;
	logic end_of_row;
	logic end_of_frame;

	floyd_steinberg_dither u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.grey_pixel   (grey_pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.halftone_bit (halftone_bit),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Model state. It mirrors what the block holds: the error owed to the next row for
	// each column, the carry to the right-hand neighbour, the two partial sums for the
	// row below, and the raster position.
	int                        line_debt [LINE_DEPTH];
	int                        carry_right;
	int                        debt_below_left;
	int                        debt_below;
	int                        pred_col;
	int                        pred_row;
	logic [WIDTH_REG_W-1:0]    pred_width;
	logic [HEIGHT_REG_W-1:0]   pred_height;

	halftone_result_t pending_halftones [$];

	int  mismatches;
	int  pixels_sent;
	int  random_pixels;
	int  frames_seen;
	bit  steady;		// both sides run without idling while this is set
	bit  hold_request;	// asks the receiver for one long hold-off

	function automatic int clamp_err(int v);
		if (v > ERR_MAX)
			return ERR_MAX;
		if (v < ERR_MIN)
			return ERR_MIN;
		return v;
	endfunction

	// An arithmetic shift rounds toward minus infinity, which is how each share rounds.
	function automatic int share16(int e, int k);
		return (e * k) >>> SHARE_SHIFT;
	endfunction

	function automatic void reset_diffusion();
		foreach (line_debt[i])
			line_debt[i] = 0;
		carry_right = 0;
		debt_below_left = 0;
		debt_below = 0;
		pred_col = 0;
		pred_row = 0;
		pred_width = WIDTH_RESET;
		pred_height = HEIGHT_RESET;
	endfunction

	// Quantizes one pixel, spreads its error and advances the raster position.
	function automatic halftone_result_t diffuse_pixel(logic [7:0] grey);
		int eff_w, eff_h, col, level, err, s7, s3, s5, s1;
		bit last_col, last_row;
		halftone_result_t r;

		// A size of zero counts as one, and a width above the line buffer counts as its depth.
		eff_w = (pred_width == 0) ? 1 : int'(pred_width);
		if (eff_w > LINE_DEPTH)
			eff_w = LINE_DEPTH;
		eff_h = (pred_height == 0) ? 1 : int'(pred_height);
		col = (pred_col >= LINE_DEPTH) ? LINE_DEPTH - 1 : pred_col;
		// A counter at or past the last position ends the row or the frame. That happens
		// after a register has shrunk the image in mid-frame.
		last_col = (col + 1 >= eff_w);
		last_row = (pred_row + 1 >= eff_h);

		level = clamp_err((int'(grey) << FRAC) + carry_right);
		// The first row of a frame owes nothing to a row above it.
		if (pred_row > 0)
			level = clamp_err(level + line_debt[col]);

		if (2 * level >= WHITE_LEVEL) begin
			r.halftone = 1'b1;
			err = level - WHITE_LEVEL;
		end else begin
			r.halftone = 1'b0;
			err = level;
		end

		s7 = share16(err, 7);
		s3 = share16(err, 3);
		s5 = share16(err, 5);
		s1 = share16(err, 1);

		// The column to the left in the next row has now had all of its shares.
		if (col > 0)
			line_debt[col - 1] = clamp_err(debt_below_left + s3);
		debt_below_left = clamp_err(debt_below + s5);
		// Shares that would land past the right edge are dropped.
		debt_below = last_col ? 0 : s1;
		carry_right = last_col ? 0 : s7;

		if (last_col) begin
			line_debt[col] = debt_below_left;
			debt_below_left = 0;
			debt_below = 0;
			pred_col = 0;
			pred_row = last_row ? 0 : pred_row + 1;
		end else begin
			pred_col = col + 1;
		end

		r.row_end = last_col;
		r.frame_end = last_col && last_row;
		return r;
	endfunction

	// Offers one pixel, with a random gap before it, and waits for its transfer. Valid is
	// left high on return. The caller either offers the next pixel at once or lowers valid.
	task automatic send_pixel(logic [7:0] grey);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		grey_pixel <= grey;
		do
			@(posedge clk);
		while (!pixel_ready);
		pending_halftones.push_back(diffuse_pixel(grey));
		pixels_sent++;
	endtask

	// Stops offering pixels and waits until every result has come back.
	task automatic wait_idle();
		pixel_valid <= 1'b0;
		while (pending_halftones.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(cfg_index_t idx, cfg_data_t value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			pred_width = value[WIDTH_REG_W-1:0];
		else
			pred_height = value[HEIGHT_REG_W-1:0];
	endtask

	task automatic set_size(int w, int h);
		wait_idle();
		write_register(REG_IMAGE_WIDTH, cfg_data_t'(w));
		write_register(REG_IMAGE_HEIGHT, cfg_data_t'(h));
	endtask

	function automatic logic [7:0] pick_grey(texture_t tex, logic [7:0] base, int idx);
		case (tex)
			TEX_FLAT: begin
				return base;
			end
			TEX_CHECKER: begin
				return idx[0] ? 8'd255 : 8'd0;
			end
			TEX_NEAR_MID: begin
				return 8'($urandom_range(120, 135));
			end
			default: begin
				return 8'($urandom);
			end
		endcase
	endfunction

	// The reset size is 640 by 480. One full row shows the reset width. The image is then
	// shrunk in mid-frame so that the frame ends after one short row.
	task automatic test_reset_size();
		for (int i = 0; i < 640; i++)
			send_pixel(8'($urandom));
		wait_idle();
		write_register(REG_IMAGE_WIDTH, cfg_data_t'(8));
		write_register(REG_IMAGE_HEIGHT, cfg_data_t'(2));
		for (int i = 0; i < 8; i++)
			send_pixel(8'($urandom));
	endtask

	// Black, white and the two levels on either side of the threshold. Whole rows of each
	// extreme follow them, so that large errors of both signs reach the rows below.
	task automatic test_level_extremes();
		logic [7:0] first_row [4];

		first_row = '{8'd0, 8'd255, 8'd127, 8'd128};
		set_size(4, 3);
		foreach (first_row[i])
			send_pixel(first_row[i]);
		repeat (4) send_pixel(8'd255);
		repeat (4) send_pixel(8'd0);
	endtask

	// A size of zero acts as one. Single-column and single-row images are tried as well.
	task automatic test_degenerate_sizes();
		set_size(0, 0);
		repeat (3) send_pixel(8'($urandom));
		set_size(1, 3);
		repeat (3) send_pixel(8'($urandom));
		set_size(2, 1);
		repeat (4) send_pixel(8'($urandom));
	endtask

	// Register writes in mid-frame. The counters are kept. A counter that is already past
	// the new size closes the row or the frame on the next pixel.
	task automatic test_midframe_writes();
		set_size(6, 4);
		repeat (10) send_pixel(8'($urandom));	// stops at row 1, column 4
		wait_idle();
		write_register(REG_IMAGE_WIDTH, cfg_data_t'(3));
		send_pixel(8'($urandom));		// column 4 is past the new width
		repeat (3) send_pixel(8'($urandom));
		wait_idle();
		write_register(REG_IMAGE_HEIGHT, 16'hFFFF);
		repeat (3) send_pixel(8'($urandom));
		wait_idle();
		write_register(REG_IMAGE_HEIGHT, cfg_data_t'(2));	// row 4 is past the last row
		repeat (3) send_pixel(8'($urandom));
		// A width that grows during the first row is safe, since that row reads no debt.
		set_size(2, 3);
		send_pixel(8'($urandom));
		wait_idle();
		write_register(REG_IMAGE_WIDTH, cfg_data_t'(5));
		repeat (14) send_pixel(8'($urandom));
	endtask

	// A width register of 4097 is clamped to the line buffer, so a long stretch of the
	// first row passes with no end of row, although its low twelve bits alone would mean a
	// width of one. The upper data bits are set as well and do not belong to the register.
	// The image is then shrunk to a single pixel, which closes the row and the frame.
	task automatic test_widest_rows();
		set_size(1, 2);
		write_register(REG_IMAGE_WIDTH, 16'hF001);
		repeat (WIDE_PIXELS) send_pixel(8'($urandom));
		wait_idle();
		write_register(REG_IMAGE_WIDTH, cfg_data_t'(1));
		write_register(REG_IMAGE_HEIGHT, cfg_data_t'(1));
		send_pixel(8'($urandom));
	endtask

	// The receiver holds off for a long stretch while pixels keep coming, so the block
	// fills up and has to stall its input.
	task automatic test_output_stall();
		set_size(5, 4);
		hold_request = 1'b1;
		repeat (20) send_pixel(8'($urandom));
	endtask

	// Several frames with no idling on either side.
	task automatic test_back_to_back();
		set_size(7, 3);
		steady = 1'b1;
		repeat (42) send_pixel(8'($urandom));
		wait_idle();
		write_register(REG_IMAGE_WIDTH, cfg_data_t'(1));
		write_register(REG_IMAGE_HEIGHT, cfg_data_t'(4));
		repeat (8) send_pixel(8'($urandom));
		steady = 1'b0;
	endtask

	// Random frames, mostly small, with random content styles. Some frames keep the size
	// of the frame before them and stream on without a pause.
	task automatic test_random_frames();
		int w, h;
		texture_t tex;
		logic [7:0] base;
		cfg_data_t data;

		w = 1;
		h = 1;
		while (random_pixels < RANDOM_TARGET) begin
			if (random_pixels == 0 || $urandom_range(0, 3) != 0) begin
				w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
				h = $urandom_range(1, 5);
				data = cfg_data_t'(w);
				// bits above the register
				data[CFG_DATA_W-1:WIDTH_REG_W] = (CFG_DATA_W-WIDTH_REG_W)'($urandom);
				wait_idle();
				write_register(REG_IMAGE_WIDTH, data);
				write_register(REG_IMAGE_HEIGHT, cfg_data_t'(h));
			end
			tex = texture_t'($urandom_range(0, 3));
			base = 8'($urandom);
			for (int i = 0; i < w * h; i++) begin
				send_pixel(pick_grey(tex, base, i));
				random_pixels++;
			end
		end
	endtask

	// Result ready. It idles at random. It is held high while the steady flag is set, and
	// held low for one long count when a hold-off is requested.
	int hold_left;

	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (steady) begin
			result_ready <= 1'b1;
		end else begin
			result_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	// A result transfer is captured at the rising clock edge and checked at the falling edge. By
	// then the prediction of a pixel accepted at the same edge is surely queued.
	halftone_result_t seen_result;
	bit               seen_valid;

	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			seen_result = '{halftone_bit, end_of_row, end_of_frame};
			seen_valid = 1'b1;
		end
	end

	always @(negedge clk) begin
		halftone_result_t want;

		if (seen_valid) begin
			seen_valid = 1'b0;
			if (seen_result.frame_end === 1'b1)
				frames_seen++;
			if (pending_halftones.size() == 0) begin
				$error("result transfer with no pixel outstanding");
				mismatches++;
			end else begin
				want = pending_halftones.pop_front();
				if (seen_result.halftone !== want.halftone) begin
					$error("halftone_bit: expected %0b, actual %0b",
						want.halftone, seen_result.halftone);
					mismatches++;
				end
				if (seen_result.row_end !== want.row_end) begin
					$error("end_of_row: expected %0b, actual %0b",
						want.row_end, seen_result.row_end);
					mismatches++;
				end
				if (seen_result.frame_end !== want.frame_end) begin
					$error("end_of_frame: expected %0b, actual %0b",
						want.frame_end, seen_result.frame_end);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: too many cycles in a row without a transfer on either channel ends the run.
	int quiet_cycles;

	always @(posedge clk) begin
		if ((pixel_valid && pixel_ready) || (result_valid && result_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
					quiet_cycles, pending_halftones.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		reset_diffusion();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_size();
		test_level_extremes();
		test_degenerate_sizes();
		test_midframe_writes();
		test_output_stall();
		test_back_to_back();
		test_widest_rows();
		test_random_frames();
		wait_idle();

		if (pending_halftones.size() != 0) begin
			$error("%0d expected results never arrived", pending_halftones.size());
			mismatches++;
		end
		$display("run covered %0d pixel transfers in %0d complete frames (%0d random pixels)",
			pixels_sent, frames_seen, random_pixels);
		$display("sizes from zero up to the widest and tallest, mid-frame writes, long output stall");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
